### src/stsu_pkg.sv
// Shared constants, types and default signature table for the signature table scanner.
package stsu_pkg;

	localparam int SIGNATURES    = 16;
	localparam int PATTERN_BYTES = 64;
	localparam int SIG_W         = $clog2(SIGNATURES);
	localparam int PAT_W         = $clog2(PATTERN_BYTES);
	localparam int CNT_W         = SIG_W + 1;
	localparam int LEN_W         = PAT_W + 1;
	localparam int SEEN_W        = 25;
	localparam int OFF_W         = 24;
	localparam int SEV_W         = 4;
	localparam int ADDR_W        = SIG_W + PAT_W;

	localparam logic [1:0] OP_INIT    = 2'd0;
	localparam logic [1:0] OP_PATTERN = 2'd1;
	localparam logic [1:0] OP_SCAN    = 2'd2;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_THREAT     = 3'd1;
	localparam logic [2:0] ST_NOT_READY  = 3'd2;
	localparam logic [2:0] ST_BAD_LENGTH = 3'd3;
	localparam logic [2:0] ST_FULL       = 3'd4;

	localparam int EICAR_LEN   = 34;
	localparam int UPX_LEN     = 4;
	localparam int DEFAULT_LEN = EICAR_LEN + UPX_LEN;
	localparam logic [SEV_W-1:0] EICAR_SEV = 4'd3;
	localparam logic [SEV_W-1:0] UPX_SEV   = 4'd2;

	typedef struct packed {
		logic accept;
		logic pat_step;
		logic init_wr;
		logic scan_push;
		logic sig_clr;
		logic sig_next;
		logic k_clr;
		logic k_next;
		logic rd_issue;
		logic set_hit;
		logic res_ok;
		logic res_scan;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       last;
		logic       ready;
		logic       seen_full;
		logic       sig_end;
		logic       sig_skip;
		logic       k_last;
		logic       cmp_eq;
		logic       init_last;
		logic       out_free;
	} dp_stat_t;

	// Default byte k of the concatenated EICAR and UPX strings.
	function automatic logic [7:0] default_byte(input logic [5:0] k);
		logic [7:0] b;
		case (k)
			6'd0:  b = "E";  6'd1:  b = "I";  6'd2:  b = "C";  6'd3:  b = "A";
			6'd4:  b = "R";  6'd5:  b = "-";  6'd6:  b = "S";  6'd7:  b = "T";
			6'd8:  b = "A";  6'd9:  b = "N";  6'd10: b = "D";  6'd11: b = "A";
			6'd12: b = "R";  6'd13: b = "D";  6'd14: b = "-";  6'd15: b = "A";
			6'd16: b = "N";  6'd17: b = "T";  6'd18: b = "I";  6'd19: b = "V";
			6'd20: b = "I";  6'd21: b = "R";  6'd22: b = "U";  6'd23: b = "S";
			6'd24: b = "-";  6'd25: b = "T";  6'd26: b = "E";  6'd27: b = "S";
			6'd28: b = "T";  6'd29: b = "-";  6'd30: b = "F";  6'd31: b = "I";
			6'd32: b = "L";  6'd33: b = "E";  6'd34: b = "U";  6'd35: b = "P";
			6'd36: b = "X";  6'd37: b = "!";
			default: b = 8'd0;
		endcase
		return b;
	endfunction

endpackage

### src/stsu_datapath.sv
// Datapath: signature store, scan window, hit tracking and result registers.
module stsu_datapath (
	input  logic                     clk,
	input  logic                     arst_n,
	input  stsu_pkg::ctrl_cmd_t      cmd,
	output stsu_pkg::dp_stat_t       stat,
	input  logic [15:0]              s_tdata,
	input  logic                     s_tlast,
	input  logic [1:0]               s_tuser,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [31:0]              m_tdata,
	output logic [2:0]               m_tuser
);

	logic [1:0]                   op_q;
	logic [7:0]                   byte_q;
	logic                         last_q;
	logic [stsu_pkg::SEV_W-1:0]   sev_q;

	logic                         ready_q;
	logic [stsu_pkg::CNT_W-1:0]   count_q;
	logic [stsu_pkg::LEN_W-1:0]   pend_q;
	logic [stsu_pkg::LEN_W-1:0]   len_q [stsu_pkg::SIGNATURES];
	logic [stsu_pkg::SEV_W-1:0]   sevtab_q [stsu_pkg::SIGNATURES];
	logic [stsu_pkg::SIGNATURES-1:0] hit_q;
	logic [stsu_pkg::OFF_W-1:0]   off_q [stsu_pkg::SIGNATURES];
	logic [stsu_pkg::SEEN_W-1:0]  seen_q;
	logic [stsu_pkg::PAT_W-1:0]   wptr_q;
	logic [stsu_pkg::CNT_W-1:0]   sig_q;
	logic [stsu_pkg::PAT_W-1:0]   k_q;
	logic [5:0]                   init_k_q;

	logic [7:0] pat_mem [1 << stsu_pkg::ADDR_W];
	logic [7:0] win_mem [stsu_pkg::PATTERN_BYTES];
	logic [7:0] pat_rdata_q;
	logic [7:0] win_rdata_q;

	logic [2:0]                  res_status_q;
	logic [stsu_pkg::SIG_W-1:0]  res_idx_q;
	logic [stsu_pkg::OFF_W-1:0]  res_off_q;
	logic [stsu_pkg::SEV_W-1:0]  res_sev_q;
	logic                        out_valid_q;
	logic [2:0]                  out_status_q;
	logic [stsu_pkg::SIG_W-1:0]  out_idx_q;
	logic [stsu_pkg::OFF_W-1:0]  out_off_q;
	logic [stsu_pkg::SEV_W-1:0]  out_sev_q;

	logic [stsu_pkg::SIG_W-1:0]  sig_idx;
	logic [stsu_pkg::LEN_W-1:0]  len_cur;
	logic [stsu_pkg::LEN_W-1:0]  pend_next;
	logic                        pat_in_range;
	logic                        mem_we;
	logic [stsu_pkg::ADDR_W-1:0] mem_waddr;
	logic [7:0]                  mem_wdata;
	logic [stsu_pkg::ADDR_W-1:0] init_addr;
	logic [stsu_pkg::PAT_W-1:0]  win_raddr;
	logic                        any_hit;
	logic [stsu_pkg::SIG_W-1:0]  first_hit;

	assign sig_idx = sig_q[stsu_pkg::SIG_W-1:0];
	assign len_cur = len_q[sig_idx];
	assign pend_next = (pend_q <= stsu_pkg::LEN_W'(stsu_pkg::PATTERN_BYTES)) ?
		pend_q + 1'b1 : pend_q;
	assign pat_in_range = (count_q < stsu_pkg::CNT_W'(stsu_pkg::SIGNATURES)) &&
		(pend_q < stsu_pkg::LEN_W'(stsu_pkg::PATTERN_BYTES));
	assign init_addr = (init_k_q < 6'(stsu_pkg::EICAR_LEN)) ?
		{stsu_pkg::SIG_W'(0), stsu_pkg::PAT_W'(init_k_q)} :
		{stsu_pkg::SIG_W'(1), stsu_pkg::PAT_W'(init_k_q - 6'(stsu_pkg::EICAR_LEN))};
	assign win_raddr = wptr_q - len_cur[stsu_pkg::PAT_W-1:0] + 1'b1 + k_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = init_addr;
		mem_wdata = stsu_pkg::default_byte(init_k_q);
		if (cmd.init_wr) begin
			mem_we = 1'b1;
		end else if (cmd.pat_step && pat_in_range) begin
			mem_we    = 1'b1;
			mem_waddr = {count_q[stsu_pkg::SIG_W-1:0], pend_q[stsu_pkg::PAT_W-1:0]};
			mem_wdata = byte_q;
		end
	end

	// Lowest-indexed signature with a hit.
	always_comb begin
		any_hit   = 1'b0;
		first_hit = '0;
		for (int i = stsu_pkg::SIGNATURES - 1; i >= 0; i--) begin
			if (hit_q[i]) begin
				any_hit   = 1'b1;
				first_hit = stsu_pkg::SIG_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			pat_mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.rd_issue) begin
			pat_rdata_q <= pat_mem[{sig_idx, k_q}];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_push) begin
			win_mem[wptr_q + 1'b1] <= byte_q;
		end
		if (cmd.rd_issue) begin
			win_rdata_q <= win_mem[win_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= s_tuser;
			byte_q <= s_tdata[7:0];
			last_q <= s_tlast;
			sev_q  <= s_tdata[11:8];
		end
		if (cmd.init_wr && stat.init_last) begin
			len_q[0]    <= stsu_pkg::LEN_W'(stsu_pkg::EICAR_LEN);
			len_q[1]    <= stsu_pkg::LEN_W'(stsu_pkg::UPX_LEN);
			sevtab_q[0] <= stsu_pkg::EICAR_SEV;
			sevtab_q[1] <= stsu_pkg::UPX_SEV;
		end
		if (cmd.pat_step && last_q && ready_q &&
			pend_next <= stsu_pkg::LEN_W'(stsu_pkg::PATTERN_BYTES) &&
			count_q < stsu_pkg::CNT_W'(stsu_pkg::SIGNATURES)) begin
			len_q[count_q[stsu_pkg::SIG_W-1:0]]    <= pend_next;
			sevtab_q[count_q[stsu_pkg::SIG_W-1:0]] <= sev_q;
		end
		if (cmd.set_hit) begin
			off_q[sig_idx] <= stsu_pkg::OFF_W'(seen_q - stsu_pkg::SEEN_W'(len_cur));
		end
		if (cmd.res_ok) begin
			res_status_q <= stsu_pkg::ST_OK;
			res_idx_q    <= '0;
			res_off_q    <= '0;
			res_sev_q    <= '0;
		end else if (cmd.pat_step) begin
			res_idx_q <= '0;
			res_off_q <= '0;
			res_sev_q <= '0;
			if (!ready_q) begin
				res_status_q <= stsu_pkg::ST_NOT_READY;
			end else if (pend_next > stsu_pkg::LEN_W'(stsu_pkg::PATTERN_BYTES)) begin
				res_status_q <= stsu_pkg::ST_BAD_LENGTH;
			end else if (count_q >= stsu_pkg::CNT_W'(stsu_pkg::SIGNATURES)) begin
				res_status_q <= stsu_pkg::ST_FULL;
			end else begin
				res_status_q <= stsu_pkg::ST_OK;
			end
		end else if (cmd.res_scan) begin
			res_status_q <= any_hit ? stsu_pkg::ST_THREAT : stsu_pkg::ST_OK;
			res_idx_q    <= any_hit ? first_hit : '0;
			res_off_q    <= any_hit ? off_q[first_hit] : '0;
			res_sev_q    <= any_hit ? sevtab_q[first_hit] : '0;
		end
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_idx_q    <= res_idx_q;
			out_off_q    <= res_off_q;
			out_sev_q    <= res_sev_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q     <= 1'b0;
			count_q     <= '0;
			pend_q      <= '0;
			hit_q       <= '0;
			seen_q      <= '0;
			wptr_q      <= '0;
			sig_q       <= '0;
			k_q         <= '0;
			init_k_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.init_wr) begin
				if (stat.init_last) begin
					init_k_q <= '0;
					ready_q  <= 1'b1;
					count_q  <= stsu_pkg::CNT_W'(2);
					hit_q[0] <= 1'b0;
					hit_q[1] <= 1'b0;
				end else begin
					init_k_q <= init_k_q + 1'b1;
				end
			end
			if (cmd.pat_step) begin
				if (last_q) begin
					pend_q <= '0;
					if (ready_q && pend_next <= stsu_pkg::LEN_W'(stsu_pkg::PATTERN_BYTES) &&
						count_q < stsu_pkg::CNT_W'(stsu_pkg::SIGNATURES)) begin
						hit_q[count_q[stsu_pkg::SIG_W-1:0]] <= 1'b0;
						count_q <= count_q + 1'b1;
					end
				end else begin
					pend_q <= pend_next;
				end
			end
			if (cmd.scan_push) begin
				wptr_q <= wptr_q + 1'b1;
				seen_q <= seen_q + 1'b1;
			end
			if (cmd.sig_clr) begin
				sig_q <= '0;
			end else if (cmd.sig_next) begin
				sig_q <= sig_q + 1'b1;
			end
			if (cmd.k_clr) begin
				k_q <= '0;
			end else if (cmd.k_next) begin
				k_q <= k_q + 1'b1;
			end
			if (cmd.set_hit) begin
				hit_q[sig_idx] <= 1'b1;
			end
			if (cmd.res_scan) begin
				hit_q  <= '0;
				seen_q <= '0;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.op        = op_q;
		stat.last      = last_q;
		stat.ready     = ready_q;
		stat.seen_full = seen_q[stsu_pkg::SEEN_W-1];
		stat.sig_end   = sig_q >= count_q;
		stat.sig_skip  = hit_q[sig_idx] ||
			(stsu_pkg::SEEN_W'(len_cur) > seen_q);
		stat.k_last    = (stsu_pkg::LEN_W'(k_q) + 1'b1) == len_cur;
		stat.cmp_eq    = pat_rdata_q == win_rdata_q;
		stat.init_last = init_k_q == 6'(stsu_pkg::DEFAULT_LEN - 1);
		stat.out_free  = !out_valid_q || m_tready;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_sev_q, out_off_q, out_idx_q};
	assign m_tuser  = out_status_q;

endmodule

### src/stsu_ctrl.sv
// Controller state machine sequencing init sweeps, pattern commits and scan compares.
module stsu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  stsu_pkg::dp_stat_t  stat,
	output stsu_pkg::ctrl_cmd_t cmd
);

	typedef enum logic [2:0] {
		IDLE, DISPATCH, INIT_WR, SIG, CMP_RD, CMP_CHK, SCAN_END, RESULT
	} state_t;

	state_t state_q;
	state_t state_d;

	assign s_tready = state_q == IDLE;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = DISPATCH;
				end
			end
			DISPATCH: begin
				case (stat.op)
					stsu_pkg::OP_INIT: begin
						if (stat.ready) begin
							cmd.res_ok = 1'b1;
							state_d    = RESULT;
						end else begin
							state_d = INIT_WR;
						end
					end
					stsu_pkg::OP_PATTERN: begin
						cmd.pat_step = 1'b1;
						state_d      = stat.last ? RESULT : IDLE;
					end
					stsu_pkg::OP_SCAN: begin
						if (!stat.seen_full) begin
							cmd.scan_push = 1'b1;
							cmd.sig_clr   = 1'b1;
							state_d       = stat.ready ? SIG : SCAN_END;
						end else begin
							state_d = SCAN_END;
						end
					end
					default: state_d = IDLE;
				endcase
			end
			INIT_WR: begin
				cmd.init_wr = 1'b1;
				if (stat.init_last) begin
					cmd.res_ok = 1'b1;
					state_d    = RESULT;
				end
			end
			SIG: begin
				if (stat.sig_end) begin
					state_d = SCAN_END;
				end else if (stat.sig_skip) begin
					cmd.sig_next = 1'b1;
				end else begin
					cmd.k_clr = 1'b1;
					state_d   = CMP_RD;
				end
			end
			CMP_RD: begin
				cmd.rd_issue = 1'b1;
				state_d      = CMP_CHK;
			end
			CMP_CHK: begin
				if (!stat.cmp_eq) begin
					cmd.sig_next = 1'b1;
					state_d      = SIG;
				end else if (stat.k_last) begin
					cmd.set_hit  = 1'b1;
					cmd.sig_next = 1'b1;
					state_d      = SIG;
				end else begin
					cmd.k_next = 1'b1;
					state_d    = CMP_RD;
				end
			end
			SCAN_END: begin
				if (stat.last) begin
					cmd.res_scan = 1'b1;
					state_d      = RESULT;
				end else begin
					state_d = IDLE;
				end
			end
			RESULT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = IDLE;
				end
			end
			default: state_d = IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### src/signature_table_scanner_unit.sv
// Top level of the signature table scanner: controller plus datapath.
//
//  channel | dir | tdata                                   | tuser       | tlast
//  s_*     | in  | [7:0] data_byte, [11:8] severity        | [1:0] op    | last byte
//  m_*     | out | [3:0] sig index, [27:4] offset, [31:28] sev | [2:0] status | none
//
// Each input word is accepted only while the controller is idle. A pattern word
// passes through the dispatch state and, when it is the last byte, the result
// state. An init word goes straight to the result once the table is ready; the
// first time it writes the 38 default signature bytes into the pattern memory. A
// scan word visits each stored signature, skipping it or comparing its bytes one
// at a time through the single read port of the pattern memory, and loads the
// result on the last byte; while the table is not ready no signature is visited.
// Reset clears all control state; no clearing pass is needed. A stalled output
// holds the controller in its result state until the word is taken.
module signature_table_scanner_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] data_byte, [11:8] severity, [15:12] zero
	input  logic        s_tlast,
	input  logic [1:0]  s_tuser,   // [1:0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [3:0] signature_index, [27:4] match_offset,
	                               // [31:28] match_severity
	output logic [2:0]  m_tuser    // [2:0] status
);

	stsu_pkg::ctrl_cmd_t cmd;
	stsu_pkg::dp_stat_t  stat;

	// The controller only issues commands; all table, buffer and result storage sits in the datapath.
	stsu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	stsu_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Only a threat result carries index, offset and severity.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != stsu_pkg::ST_THREAT |-> m_tdata == 32'd0)
		else $error("non-threat result carries payload");

	// A word is worked on alone: after an accept the input side closes.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while busy");

	// A new result is only loaded once the previous one has left.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> stat.out_free)
		else $error("result overwritten before delivery");

endmodule

### bench/testbench.sv
// Self-checking bench for the signature table scanner unit.
`timescale 1ns / 100ps

module testbench;

	localparam logic [1:0] OP_NOISE = 2'd3;
	localparam int IDLE_PCT = 19;
	localparam int STALL_LIMIT = 40000;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic [1:0]                 op;
		logic [7:0]                 data;
		logic                       last;
		logic [stsu_pkg::SEV_W-1:0] sev;
	} word_t;

	typedef struct {
		logic [2:0]                 status;
		logic [stsu_pkg::SIG_W-1:0] index;
		logic [stsu_pkg::OFF_W-1:0] offset;
		logic [stsu_pkg::SEV_W-1:0] sev;
	} verdict_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        s_tlast;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [2:0]  m_tuser;

	signature_table_scanner_unit dut (.*);

	// Predictor state: a copy of the signature table and of the buffer window.
	logic [7:0]                 sig_bytes [stsu_pkg::SIGNATURES][stsu_pkg::PATTERN_BYTES];
	logic [stsu_pkg::LEN_W-1:0] sig_len [stsu_pkg::SIGNATURES];
	logic [stsu_pkg::SEV_W-1:0] sig_sev [stsu_pkg::SIGNATURES];
	int                         sig_count;
	bit                         table_on;
	int                         open_len;
	logic [7:0]                 window [stsu_pkg::PATTERN_BYTES];
	longint                     buf_bytes;
	bit                         hit [stsu_pkg::SIGNATURES];
	logic [stsu_pkg::OFF_W-1:0] hit_at [stsu_pkg::SIGNATURES];

	verdict_t expected_q [$];
	int errors;
	int quiet_cycles;
	bit calm;
	bit hold_req;
	int hold_left;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic bit sig_ends_here(input int s);
		int n;
		n = sig_len[s];
		if (n == 0 || n > stsu_pkg::PATTERN_BYTES || n > buf_bytes) return 0;
		for (int k = 0; k < n; k++)
			if (sig_bytes[s][k] !== window[n - 1 - k]) return 0;
		return 1;
	endfunction

	task automatic clear_buffer();
		for (int i = 0; i < stsu_pkg::PATTERN_BYTES; i++) window[i] = 8'd0;
		buf_bytes = 0;
		for (int s = 0; s < stsu_pkg::SIGNATURES; s++) begin
			hit[s] = 0;
			hit_at[s] = '0;
		end
	endtask

	// Works out the verdict, if any, that one accepted word must produce.
	task automatic predict_verdict(input word_t w);
		verdict_t v;
		int n;
		v = '{stsu_pkg::ST_OK, '0, '0, '0};
		case (w.op)
			stsu_pkg::OP_INIT: begin
				if (!table_on) begin
					for (int k = 0; k < stsu_pkg::EICAR_LEN; k++)
						sig_bytes[0][k] = stsu_pkg::default_byte(6'(k));
					for (int k = 0; k < stsu_pkg::UPX_LEN; k++)
						sig_bytes[1][k] = stsu_pkg::default_byte(6'(stsu_pkg::EICAR_LEN + k));
					sig_len[0] = stsu_pkg::LEN_W'(stsu_pkg::EICAR_LEN);
					sig_len[1] = stsu_pkg::LEN_W'(stsu_pkg::UPX_LEN);
					sig_sev[0] = stsu_pkg::EICAR_SEV;
					sig_sev[1] = stsu_pkg::UPX_SEV;
					hit[0] = 0;
					hit[1] = 0;
					sig_count = 2;
					table_on = 1;
				end
				expected_q.push_back(v);
			end
			stsu_pkg::OP_PATTERN: begin
				if (sig_count < stsu_pkg::SIGNATURES && open_len < stsu_pkg::PATTERN_BYTES)
					sig_bytes[sig_count][open_len] = w.data;
				if (open_len <= stsu_pkg::PATTERN_BYTES) open_len++;
				if (w.last) begin
					n = open_len;
					open_len = 0;
					if (!table_on) v.status = stsu_pkg::ST_NOT_READY;
					else if (n > stsu_pkg::PATTERN_BYTES) v.status = stsu_pkg::ST_BAD_LENGTH;
					else if (sig_count >= stsu_pkg::SIGNATURES) v.status = stsu_pkg::ST_FULL;
					else begin
						sig_len[sig_count] = stsu_pkg::LEN_W'(n);
						sig_sev[sig_count] = w.sev;
						hit[sig_count] = 0;
						hit_at[sig_count] = '0;
						sig_count++;
					end
					expected_q.push_back(v);
				end
			end
			stsu_pkg::OP_SCAN: begin
				if (buf_bytes < (64'd1 << stsu_pkg::OFF_W)) begin
					for (int i = stsu_pkg::PATTERN_BYTES - 1; i > 0; i--) window[i] = window[i-1];
					window[0] = w.data;
					buf_bytes++;
					if (table_on)
						for (int s = 0; s < sig_count; s++)
							if (!hit[s] && sig_ends_here(s)) begin
								hit[s] = 1;
								hit_at[s] = stsu_pkg::OFF_W'(buf_bytes - sig_len[s]);
							end
				end
				if (w.last) begin
					if (table_on)
						for (int s = 0; s < sig_count; s++)
							if (hit[s]) begin
								v = '{stsu_pkg::ST_THREAT, stsu_pkg::SIG_W'(s), hit_at[s],
									sig_sev[s]};
								break;
							end
					expected_q.push_back(v);
					clear_buffer();
				end
			end
			default: ;
		endcase
	endtask

	// Offers one word, idling at random first, and predicts once it is taken.
	task automatic send_word(input word_t w);
		if (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= w.op;
		s_tdata <= {4'd0, w.sev, w.data};
		s_tlast <= w.last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_verdict(w);
	endtask

	task automatic send_signature(input logic [7:0] pat [$],
		input logic [stsu_pkg::SEV_W-1:0] sev);
		foreach (pat[i]) send_word('{stsu_pkg::OP_PATTERN, pat[i], i == pat.size() - 1, sev});
	endtask

	task automatic send_buffer(input logic [7:0] bytes [$]);
		foreach (bytes[i])
			send_word('{stsu_pkg::OP_SCAN, bytes[i], i == bytes.size() - 1, 4'($urandom)});
	endtask

	function automatic logic [7:0] pick_byte();
		logic [7:0] menu [4] = '{"A", "U", "P", "X"};
		return ($urandom_range(3) == 0) ? 8'($urandom) : menu[$urandom_range(3)];
	endfunction

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Before init: a buffer answers clean, a noise word is ignored and a signature is refused.
	task automatic test_before_init();
		send_buffer('{8'h00, 8'hFF, "U"});
		send_word('{OP_NOISE, 8'hA5, 1'b1, 4'hF});
		send_signature('{8'h11, 8'h22}, 4'hF);
	endtask

	// Defaults: init twice, then a buffer holding the UPX string and one holding both default strings.
	task automatic test_defaults();
		logic [7:0] b [$];
		send_word('{stsu_pkg::OP_INIT, 8'h00, 1'b0, 4'h0});
		send_word('{stsu_pkg::OP_INIT, 8'hFF, 1'b1, 4'hF});
		b = '{"x", "U", "P", "X", "!"};
		send_buffer(b);
		b = '{"U", "P", "X", "!"};
		for (int k = 0; k < stsu_pkg::EICAR_LEN; k++) b.push_back(stsu_pkg::default_byte(6'(k)));
		send_buffer(b);
	endtask

	// Length limits, a one-byte signature and a commit in the middle of a scan.
	task automatic test_lengths();
		logic [7:0] p [$];
		for (int k = 0; k < stsu_pkg::PATTERN_BYTES + 1; k++) p.push_back(8'($urandom));
		send_signature(p, 4'h9);
		void'(p.pop_back());
		send_signature(p, 4'hF);
		send_signature('{8'hFF}, 4'h0);
		send_word('{stsu_pkg::OP_SCAN, "Q", 1'b0, 4'h0});
		send_signature('{"Q", "Z"}, 4'h7);
		send_buffer('{"Z", "Q", "Z", 8'hFF});
	endtask

	// Random traffic, mostly well-formed signatures and buffers often seeded with
	// copies of stored signatures, plus init words, noise and overlong signatures.
	task automatic test_random(input int words);
		int sent;
		int r;
		int n;
		int s;
		int at;
		logic [7:0] b [$];
		sent = 0;
		while (sent < words) begin
			calm = (sent > 300 && sent < 500);
			if (sent > 700 && sent < 760 && hold_left == 0) hold_req = 1;
			if (sent > 1000 && sent < 1040) begin
				wait_drained();
				sent = 1040;
			end
			r = $urandom_range(99);
			b.delete();
			if (r < 7 && sig_count < stsu_pkg::SIGNATURES - 2) begin
				n = $urandom_range(1, 6);
				repeat (n) b.push_back(pick_byte());
				send_signature(b, 4'($urandom));
				sent += n;
			end else if (r < 9) begin
				send_word('{stsu_pkg::OP_INIT, 8'($urandom), 1'($urandom), 4'($urandom)});
				sent++;
			end else if (r < 12) begin
				send_word('{OP_NOISE, 8'($urandom), 1'($urandom), 4'($urandom)});
			end else if (r < 13) begin
				n = $urandom_range(stsu_pkg::PATTERN_BYTES + 1, stsu_pkg::PATTERN_BYTES + 4);
				repeat (n) b.push_back(8'($urandom));
				send_signature(b, 4'($urandom));
				sent += n;
			end else begin
				n = $urandom_range(1, 24);
				repeat (n) b.push_back(pick_byte());
				if ($urandom_range(9) < 6 && sig_count > 0) begin
					s = $urandom_range(sig_count - 1);
					at = $urandom_range(n);
					for (int k = sig_len[s] - 1; k >= 0; k--) b.insert(at, sig_bytes[s][k]);
				end
				send_buffer(b);
				sent += b.size();
			end
		end
	endtask

	// Fill the table, overflow it, and find the last slot.
	task automatic test_full_table();
		while (sig_count < stsu_pkg::SIGNATURES)
			send_signature('{"F", 8'(sig_count), "#"}, 4'(sig_count));
		send_signature('{"o", "v"}, 4'h1);
		send_buffer('{"F", 8'(stsu_pkg::SIGNATURES - 1), "#", "!"});
	endtask

	// Result side: check each word, then pick the next ready level.
	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected word", m_tuser, 0);
				end else begin
					want = expected_q.pop_front();
					if (m_tuser !== want.status) report_mismatch("status", m_tuser, want.status);
					if (m_tdata[3:0] !== want.index)
						report_mismatch("signature_index", m_tdata[3:0], want.index);
					if (m_tdata[27:4] !== want.offset)
						report_mismatch("match_offset", m_tdata[27:4], want.offset);
					if (m_tdata[31:28] !== want.sev)
						report_mismatch("match_severity", m_tdata[31:28], want.sev);
				end
			end
			if (hold_req && hold_left == 0) begin
				hold_req = 0;
				hold_left <= HOLD_CYCLES;
				m_tready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Watchdog: ends the run when no word moves for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		errors = 0;
		quiet_cycles = 0;
		calm = 0;
		hold_req = 0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		s_tuser = stsu_pkg::OP_INIT;
		for (int s = 0; s < stsu_pkg::SIGNATURES; s++) sig_len[s] = '0;
		sig_count = 0;
		table_on = 0;
		open_len = 0;
		clear_buffer();
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_before_init();
		test_defaults();
		test_lengths();
		test_random(1120);
		test_full_table();
		wait_drained();
		if (errors == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end

endmodule
